/* src/swipe_gesture_detector_assert.svh */
// Assertion macros shared by the swipe gesture detector.
`ifndef SWIPE_GESTURE_DETECTOR_ASSERT_SVH
`define SWIPE_GESTURE_DETECTOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SGD_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SGD_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

/* src/sgd_pkg.sv */
// Package with types, constants and helpers of the swipe gesture detector.
package sgd_pkg;
  localparam int CoordBits = 12;
  localparam int TimeBits = 24;
  localparam int LenBits = 13;
  localparam int SqBits = 2 * CoordBits + 2;
  localparam int RootBits = SqBits / 2 + 10;
  localparam int RadBits = 2 * RootBits;
  localparam int DivBits = SqBits + 31;

  typedef enum logic [1:0] {
    REQ_DOWN = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_UP   = 2'd2,
    REQ_TICK = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_MIN_DIST  = 2'd0,
    CFG_MIN_SPEED = 2'd1,
    CFG_ANGLE_EN  = 2'd2,
    CFG_COS_TOL   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] tick_ms;
  } in_beat_t;

  typedef struct packed {
    logic               swipe_done;
    logic               stroke_valid;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [15:0]        swipe_speed;
    logic [12:0]        swipe_length;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE_DIRX,
    ST_MOVE_DIRY,
    ST_MOVE_CHECK,
    ST_MOVE_LEN,
    ST_MOVE_SPEED,
    ST_OUT_DIRX,
    ST_OUT_DIRY,
    ST_SEND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input beat and apply down, up, tick or move head
    logic op_start;   // start the shared iterative unit
    logic [2:0] op;   // which computation the unit runs
    logic apply_check;
    logic store_len;
    logic store_speed;
    logic store_odx;
    logic store_ody;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_done;
    logic move_active; // move leaves the anchor on a valid stroke
  } status_t;

  localparam logic [2:0] OP_DIR_NX = 3'd0;
  localparam logic [2:0] OP_DIR_NY = 3'd1;
  localparam logic [2:0] OP_LEN    = 3'd2;
  localparam logic [2:0] OP_SPEED  = 3'd3;
  localparam logic [2:0] OP_DIR_OX = 3'd4;
  localparam logic [2:0] OP_DIR_OY = 3'd5;
endpackage

/* src/swipe_gesture_detector.sv */
// Top level of the swipe gesture detector.
// Each beat in gives one beat out, and beats are taken one at a time. The
// shared square, divide and square-root unit sets the time: a direction
// component runs a divide and a root (only the square for a zero vector), the
// length a root, and the speed a root and, when elapsed time is nonzero, a
// division by that time. A beat that is not a move leaving the anchor computes
// only the output direction; a move that leaves the anchor first computes the
// new direction, the turn check, the length and the speed. The next beat can be
// accepted in the cycle the result appears; a result still waiting in the output
// register only holds the block in its send step. There is no clearing pass
// after reset.
module swipe_gesture_detector (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  sgd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sgd_pkg::out_beat_t out_data
);
  sgd_pkg::cmd_t    cmd;
  sgd_pkg::status_t status;

  sgd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  sgd_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_beat(in_data), .cmd(cmd), .status(status),
    .out_beat(out_data)
  );

`include "swipe_gesture_detector_assert.svh"
  `SGD_ASSERT_IMP(a_done_only_up, clk, rst, out_valid && out_data.swipe_done, out_data.stroke_valid, "swipe flagged on invalid stroke")
  `SGD_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "second beat taken while busy")
endmodule

/* src/sgd_ctrl.sv */
// Controller state machine of the swipe gesture detector.
module sgd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sgd_pkg::status_t  status,
  output sgd_pkg::cmd_t     cmd
);
  sgd_pkg::state_t state, state_next;
  logic out_full, out_full_next;

  // The output register frees when taken; a new beat may enter meanwhile.
  assign in_ready = (state == sgd_pkg::ST_IDLE);
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgd_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sgd_pkg::ST_IDLE: begin
        if (in_valid) state_next = sgd_pkg::ST_MOVE_DIRX;
      end
      sgd_pkg::ST_MOVE_DIRX: begin
        if (!status.move_active) state_next = sgd_pkg::ST_OUT_DIRX;
        else if (status.op_done) state_next = sgd_pkg::ST_MOVE_DIRY;
      end
      sgd_pkg::ST_MOVE_DIRY: if (status.op_done) state_next = sgd_pkg::ST_MOVE_CHECK;
      sgd_pkg::ST_MOVE_CHECK: state_next = sgd_pkg::ST_MOVE_LEN;
      sgd_pkg::ST_MOVE_LEN: if (status.op_done) state_next = sgd_pkg::ST_MOVE_SPEED;
      sgd_pkg::ST_MOVE_SPEED: if (status.op_done) state_next = sgd_pkg::ST_OUT_DIRX;
      sgd_pkg::ST_OUT_DIRX: if (status.op_done) state_next = sgd_pkg::ST_OUT_DIRY;
      sgd_pkg::ST_OUT_DIRY: if (status.op_done) state_next = sgd_pkg::ST_SEND;
      sgd_pkg::ST_SEND: if (!out_full || out_ready) state_next = sgd_pkg::ST_IDLE;
      default: state_next = sgd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_full_next = out_full && !out_ready;
    unique case (state)
      sgd_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      sgd_pkg::ST_MOVE_DIRX: begin
        cmd.op = sgd_pkg::OP_DIR_NX;
        cmd.op_start = status.move_active && !status.op_done;
        if (status.op_done) begin
          cmd.op = sgd_pkg::OP_DIR_NY;
          cmd.op_start = 1'b1;
        end else if (!status.move_active) begin
          cmd.op = sgd_pkg::OP_DIR_OX;
          cmd.op_start = 1'b1;
        end
      end
      sgd_pkg::ST_MOVE_DIRY: begin
        cmd.op = sgd_pkg::OP_DIR_NY;
      end
      sgd_pkg::ST_MOVE_CHECK: begin
        cmd.apply_check = 1'b1;
        cmd.op = sgd_pkg::OP_LEN;
        cmd.op_start = 1'b1;
      end
      sgd_pkg::ST_MOVE_LEN: begin
        cmd.op = sgd_pkg::OP_LEN;
        cmd.store_len = status.op_done;
        if (status.op_done) begin
          cmd.op = sgd_pkg::OP_SPEED;
          cmd.op_start = 1'b1;
        end
      end
      sgd_pkg::ST_MOVE_SPEED: begin
        cmd.op = sgd_pkg::OP_SPEED;
        cmd.store_speed = status.op_done;
        if (status.op_done) begin
          cmd.op = sgd_pkg::OP_DIR_OX;
          cmd.op_start = 1'b1;
        end
      end
      sgd_pkg::ST_OUT_DIRX: begin
        cmd.op = sgd_pkg::OP_DIR_OX;
        cmd.store_odx = status.op_done;
        if (status.op_done) begin
          cmd.op = sgd_pkg::OP_DIR_OY;
          cmd.op_start = 1'b1;
        end
      end
      sgd_pkg::ST_OUT_DIRY: begin
        cmd.op = sgd_pkg::OP_DIR_OY;
        cmd.store_ody = status.op_done;
      end
      sgd_pkg::ST_SEND: begin
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end
endmodule

/* src/sgd_datapath.sv */
// Datapath of the swipe gesture detector: stroke state and iterative unit.
module sgd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  sgd_pkg::in_beat_t  in_beat,
  input  sgd_pkg::cmd_t      cmd,
  output sgd_pkg::status_t   status,
  output sgd_pkg::out_beat_t out_beat
);
  localparam int CB = sgd_pkg::CoordBits;
  localparam int SB = sgd_pkg::SqBits;
  localparam int RB = sgd_pkg::RootBits;
  localparam int AB = sgd_pkg::RadBits;
  localparam int DB = sgd_pkg::DivBits;
  localparam int TB = sgd_pkg::TimeBits;
  localparam logic [TB-1:0] TimeMax = {TB{1'b1}};

  // Configuration.
  logic [12:0] min_dist;
  logic [15:0] min_speed;
  logic        angle_en;
  logic signed [15:0] cos_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= '0;
      min_speed <= '0;
      angle_en <= 1'b0;
      cos_tol <= 16'sd32767;
    end else if (cfg_we) begin
      unique case (sgd_pkg::cfg_index_t'(cfg_index))
        sgd_pkg::CFG_MIN_DIST:  min_dist <= cfg_data[12:0];
        sgd_pkg::CFG_MIN_SPEED: min_speed <= cfg_data;
        sgd_pkg::CFG_ANGLE_EN:  angle_en <= cfg_data[0];
        sgd_pkg::CFG_COS_TOL:   cos_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stroke state.
  logic [CB-1:0] start_x, start_y, current_x, current_y, anchor_x, anchor_y;
  logic signed [15:0] last_dir_x, last_dir_y, new_dir_x, new_dir_y;
  logic signed [15:0] out_dir_x, out_dir_y;
  logic have_direction, stroke_ok, move_active, done;
  logic [TB-1:0] elapsed_ms;
  logic [15:0] speed_reg;
  logic [12:0] length_reg;

  logic signed [CB:0] adx, ady, sdx, sdy;
  assign adx = signed'({1'b0, current_x}) - signed'({1'b0, anchor_x});
  assign ady = signed'({1'b0, current_y}) - signed'({1'b0, anchor_y});
  assign sdx = signed'({1'b0, current_x}) - signed'({1'b0, start_x});
  assign sdy = signed'({1'b0, current_y}) - signed'({1'b0, start_y});

  logic [TB:0] elapsed_sum;
  assign elapsed_sum = {1'b0, elapsed_ms} + {{(TB-15){1'b0}}, in_beat.tick_ms};

  // Shared iterative unit: a squaring step, an optional restoring division,
  // a bit-serial square root, and for the speed a division by elapsed time.
  typedef enum logic [2:0] {U_IDLE, U_SQ, U_DIV, U_ROOT, U_SLOAD, U_SDIV} unit_st_t;
  unit_st_t ust;
  logic [2:0] uop;
  logic [CB-1:0] ua, ub;
  logic [SB-1:0] d2;
  logic [DB-1:0] quo;
  logic [SB:0] rem, rem_sh, rem_w;
  logic div_ge;
  logic [5:0] cnt;
  logic [AB-1:0] rad, rrem, root_sh;
  logic root_ge;
  logic [RB-1:0] root;
  logic op_done, unit_fin;
  logic [RB-1:0] snum, sq;
  logic [TB:0] srem, srem_sh;

  logic [CB-1:0] mag_a, mag_b;
  always_comb begin
    unique case (cmd.op)
      sgd_pkg::OP_DIR_NX: begin
        mag_a = adx[CB] ? CB'(-adx) : adx[CB-1:0];
        mag_b = ady[CB] ? CB'(-ady) : ady[CB-1:0];
      end
      sgd_pkg::OP_DIR_NY: begin
        mag_a = ady[CB] ? CB'(-ady) : ady[CB-1:0];
        mag_b = adx[CB] ? CB'(-adx) : adx[CB-1:0];
      end
      sgd_pkg::OP_DIR_OY: begin
        mag_a = sdy[CB] ? CB'(-sdy) : sdy[CB-1:0];
        mag_b = sdx[CB] ? CB'(-sdx) : sdx[CB-1:0];
      end
      default: begin
        mag_a = sdx[CB] ? CB'(-sdx) : sdx[CB-1:0];
        mag_b = sdy[CB] ? CB'(-sdy) : sdy[CB-1:0];
      end
    endcase
  end

  logic [SB-1:0] sq_a, sq_b;
  assign sq_a = SB'(ua) * SB'(ua);
  assign sq_b = SB'(ub) * SB'(ub);

  assign rem_sh = {rem[SB-1:0], quo[DB-1]};
  assign div_ge = rem_sh >= {1'b0, d2};
  assign rem_w = rem_sh - {1'b0, d2};
  assign root_sh = {rrem[AB-3:0], rad[AB-1:AB-2]};
  assign root_ge = root_sh >= AB'({root, 2'b01});
  assign srem_sh = {srem[TB-1:0], snum[RB-1]};

  assign unit_fin =
      (ust == U_SQ && uop != sgd_pkg::OP_LEN && uop != sgd_pkg::OP_SPEED &&
       (sq_a + sq_b) == '0) ||
      (ust == U_ROOT && cnt == 6'd1 &&
       !(uop == sgd_pkg::OP_SPEED && elapsed_ms != '0)) ||
      (ust == U_SDIV && cnt == 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ust <= U_IDLE;
      op_done <= 1'b0;
    end else begin
      op_done <= unit_fin;
      unique case (ust)
        U_IDLE: if (cmd.op_start) begin
          ust <= U_SQ;
          uop <= cmd.op;
          ua <= mag_a;
          ub <= mag_b;
        end
        U_SQ: begin
          d2 <= sq_a + sq_b;
          if (uop == sgd_pkg::OP_LEN) begin
            rad <= AB'(sq_a + sq_b);
            rrem <= '0;
            root <= '0;
            cnt <= 6'(RB);
            ust <= U_ROOT;
          end else if (uop == sgd_pkg::OP_SPEED) begin
            // The speed root is taken of the squared length times one million.
            rad <= AB'((sq_a + sq_b)) * AB'(1000000);
            rrem <= '0;
            root <= '0;
            cnt <= 6'(RB);
            ust <= U_ROOT;
          end else if ((sq_a + sq_b) == '0) begin
            root <= '0;
            ust <= U_IDLE;
          end else begin
            quo <= DB'(sq_a) << 30;
            rem <= '0;
            cnt <= 6'(DB);
            ust <= U_DIV;
          end
        end
        U_DIV: begin
          if (div_ge) begin
            rem <= rem_w;
            quo <= {quo[DB-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DB-2:0], 1'b0};
          end
          if (cnt == 6'd1) begin
            ust <= U_ROOT;
            cnt <= 6'(RB);
            rrem <= '0;
            root <= '0;
            rad <= AB'({quo[DB-2:0], div_ge});
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        U_ROOT: begin
          if (root_ge) begin
            rrem <= root_sh - AB'({root, 2'b01});
            root <= {root[RB-2:0], 1'b1};
          end else begin
            rrem <= root_sh;
            root <= {root[RB-2:0], 1'b0};
          end
          rad <= {rad[AB-3:0], 2'b00};
          if (cnt == 6'd1) begin
            if (uop == sgd_pkg::OP_SPEED && elapsed_ms != '0) ust <= U_SLOAD;
            else ust <= U_IDLE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        U_SLOAD: begin
          snum <= root;
          sq <= '0;
          srem <= '0;
          cnt <= 6'(RB);
          ust <= U_SDIV;
        end
        U_SDIV: begin
          snum <= {snum[RB-2:0], 1'b0};
          if (srem_sh >= {1'b0, elapsed_ms}) begin
            srem <= srem_sh - {1'b0, elapsed_ms};
            sq <= {sq[RB-2:0], 1'b1};
          end else begin
            srem <= srem_sh;
            sq <= {sq[RB-2:0], 1'b0};
          end
          if (cnt == 6'd1) ust <= U_IDLE;
          else cnt <= cnt - 6'd1;
        end
        default: ust <= U_IDLE;
      endcase
    end
  end

  assign status.op_done = op_done;
  assign status.move_active = move_active;

  logic [RB-1:0] q15;
  assign q15 = (root > RB'(32767)) ? RB'(32767) : root;

  // Turn check product.
  logic signed [33:0] dot;
  logic signed [31:0] tol_scaled;
  assign dot = 34'(new_dir_x * last_dir_x) + 34'(new_dir_y * last_dir_y);
  assign tol_scaled = 32'(cos_tol) <<< 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0; start_y <= '0; current_x <= '0; current_y <= '0;
      anchor_x <= '0; anchor_y <= '0; last_dir_x <= '0; last_dir_y <= '0;
      have_direction <= 1'b0; stroke_ok <= 1'b1; elapsed_ms <= '0;
      speed_reg <= '0; length_reg <= '0; move_active <= 1'b0; done <= 1'b0;
    end else begin
      if (cmd.load) begin
        move_active <= (in_beat.req_type == sgd_pkg::REQ_MOVE) && stroke_ok &&
                       ((in_beat.pos_x != anchor_x) || (in_beat.pos_y != anchor_y));
        done <= (in_beat.req_type == sgd_pkg::REQ_UP) && stroke_ok &&
                (speed_reg >= min_speed) && (length_reg >= min_dist);
        unique case (sgd_pkg::req_type_t'(in_beat.req_type))
          sgd_pkg::REQ_DOWN: begin
            start_x <= in_beat.pos_x; current_x <= in_beat.pos_x;
            anchor_x <= in_beat.pos_x;
            start_y <= in_beat.pos_y; current_y <= in_beat.pos_y;
            anchor_y <= in_beat.pos_y;
            elapsed_ms <= '0; speed_reg <= '0; stroke_ok <= 1'b1;
            have_direction <= 1'b0; last_dir_x <= '0; last_dir_y <= '0;
            length_reg <= '0;
          end
          sgd_pkg::REQ_MOVE: if (stroke_ok) begin
            current_x <= in_beat.pos_x;
            current_y <= in_beat.pos_y;
          end
          sgd_pkg::REQ_UP: ;
          sgd_pkg::REQ_TICK: if (stroke_ok) begin
            elapsed_ms <= elapsed_sum[TB] ? TimeMax : elapsed_sum[TB-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.op_start && cmd.op == sgd_pkg::OP_DIR_NY) begin
        new_dir_x <= adx[CB] ? -16'(q15) : 16'(q15);
      end
      if (status.op_done && cmd.op == sgd_pkg::OP_DIR_NY && !cmd.op_start) begin
        new_dir_y <= ady[CB] ? -16'(q15) : 16'(q15);
      end
      if (cmd.apply_check) begin
        if (have_direction) begin
          if (angle_en) begin
            if (dot >= 34'(tol_scaled)) begin
              anchor_x <= current_x; anchor_y <= current_y;
              last_dir_x <= new_dir_x; last_dir_y <= new_dir_y;
            end else begin
              stroke_ok <= 1'b0;
            end
          end else begin
            stroke_ok <= 1'b1;
          end
        end else begin
          anchor_x <= current_x; anchor_y <= current_y;
          last_dir_x <= new_dir_x; last_dir_y <= new_dir_y;
          have_direction <= 1'b1;
        end
      end
      if (cmd.store_len) begin
        length_reg <= (root > RB'(8191)) ? 13'd8191 : root[12:0];
      end
      if (cmd.store_speed) begin
        if (elapsed_ms == '0) begin
          speed_reg <= (d2 != '0) ? 16'hFFFF : 16'h0000;
        end else begin
          speed_reg <= (sq > RB'(65535)) ? 16'hFFFF : sq[15:0];
        end
      end
      if (cmd.store_odx) out_dir_x <= sdx[CB] ? -16'(q15) : 16'(q15);
      if (cmd.store_ody) out_dir_y <= sdy[CB] ? -16'(q15) : 16'(q15);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat.swipe_done <= done;
      out_beat.stroke_valid <= stroke_ok;
      out_beat.dir_x <= out_dir_x;
      out_beat.dir_y <= out_dir_y;
      out_beat.swipe_speed <= speed_reg;
      out_beat.swipe_length <= length_reg;
    end
  end
endmodule

/* bench/testbench.sv */
// Self-checking testbench for the swipe gesture detector.
`timescale 1ns / 100ps

class swipe_scoreboard;
  // Configuration copy.
  logic [12:0] min_dist;
  logic [15:0] min_speed;
  logic        angle_en;
  logic signed [15:0] cos_tol;
  // Stroke state copy.
  logic [11:0] sx, sy, cx, cy, ax, ay;
  logic signed [15:0] ldx, ldy;
  logic        have_dir, ok;
  logic [23:0] elapsed;
  logic [15:0] speed;
  logic [12:0] len;
  sgd_pkg::out_beat_t pending[$];
  int errors;

  function new();
    min_dist = 0; min_speed = 0; angle_en = 0; cos_tol = 16'sd32767;
    sx = 0; sy = 0; cx = 0; cy = 0; ax = 0; ay = 0; ldx = 0; ldy = 0;
    have_dir = 0; ok = 1; elapsed = 0; speed = 0; len = 0; errors = 0;
  endfunction

  function void write_reg(sgd_pkg::cfg_index_t idx, logic [15:0] v);
    case (idx)
      sgd_pkg::CFG_MIN_DIST: min_dist = v[12:0];
      sgd_pkg::CFG_MIN_SPEED: min_speed = v;
      sgd_pkg::CFG_ANGLE_EN: angle_en = v[0];
      default: cos_tol = v;
    endcase
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  static function void unit_vec(longint dx, longint dy, output logic signed [15:0] ux,
                                output logic signed [15:0] uy);
    longint unsigned adx, ady, d2, mx, my;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    d2 = adx * adx + ady * ady;
    if (d2 == 0) begin
      ux = 0;
      uy = 0;
    end else begin
      mx = int_sqrt(((adx * adx) << 30) / d2);
      my = int_sqrt(((ady * ady) << 30) / d2);
      if (mx > 32767) mx = 32767;
      if (my > 32767) my = 32767;
      ux = dx < 0 ? -16'(mx) : 16'(mx);
      uy = dy < 0 ? -16'(my) : 16'(my);
    end
  endfunction

  function void note_input(sgd_pkg::in_beat_t b);
    sgd_pkg::out_beat_t r;
    logic signed [15:0] nx, ny;
    longint dot, ddx, ddy;
    longint unsigned d2, root, sp, t;
    r = '0;
    case (sgd_pkg::req_type_t'(b.req_type))
      sgd_pkg::REQ_DOWN: begin
        sx = b.pos_x; cx = b.pos_x; ax = b.pos_x;
        sy = b.pos_y; cy = b.pos_y; ay = b.pos_y;
        elapsed = 0; speed = 0; ok = 1; have_dir = 0; ldx = 0; ldy = 0; len = 0;
      end
      sgd_pkg::REQ_MOVE: begin
        if (ok) begin
          cx = b.pos_x;
          cy = b.pos_y;
          if (cx != ax || cy != ay) begin
            unit_vec(longint'(cx) - longint'(ax), longint'(cy) - longint'(ay), nx, ny);
            if (have_dir) begin
              if (angle_en) begin
                dot = longint'(nx) * ldx + longint'(ny) * ldy;
                if (dot >= longint'(cos_tol) * 32768) begin
                  ax = cx; ay = cy; ldx = nx; ldy = ny;
                end else begin
                  ok = 0;
                end
              end else begin
                ok = 1;
              end
            end else begin
              ax = cx; ay = cy; ldx = nx; ldy = ny; have_dir = 1;
            end
            ddx = longint'(cx) - longint'(sx);
            ddy = longint'(cy) - longint'(sy);
            d2 = ddx * ddx + ddy * ddy;
            root = int_sqrt(d2);
            len = root > 8191 ? 13'd8191 : root[12:0];
            if (elapsed == 0) begin
              speed = d2 != 0 ? 16'hFFFF : 16'h0;
            end else begin
              sp = int_sqrt(d2 * 1000000) / elapsed;
              speed = sp > 65535 ? 16'hFFFF : sp[15:0];
            end
          end
        end
      end
      sgd_pkg::REQ_UP: begin
        r.swipe_done = ok && speed >= min_speed && len >= min_dist;
      end
      default: begin
        if (ok) begin
          t = longint'(elapsed) + b.tick_ms;
          elapsed = t > 24'hFFFFFF ? 24'hFFFFFF : t[23:0];
        end
      end
    endcase
    unit_vec(longint'(cx) - longint'(sx), longint'(cy) - longint'(sy), nx, ny);
    r.stroke_valid = ok;
    r.dir_x = nx;
    r.dir_y = ny;
    r.swipe_speed = speed;
    r.swipe_length = len;
    pending.push_back(r);
  endfunction

  function void check_result(sgd_pkg::out_beat_t got);
    sgd_pkg::out_beat_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.swipe_done !== e.swipe_done)
      $display("%0t: swipe_done exp %0d got %0d", $time, e.swipe_done, got.swipe_done);
    if (got.stroke_valid !== e.stroke_valid)
      $display("%0t: stroke_valid exp %0d got %0d", $time, e.stroke_valid, got.stroke_valid);
    if (got.dir_x !== e.dir_x)
      $display("%0t: dir_x exp %0d got %0d", $time, e.dir_x, got.dir_x);
    if (got.dir_y !== e.dir_y)
      $display("%0t: dir_y exp %0d got %0d", $time, e.dir_y, got.dir_y);
    if (got.swipe_speed !== e.swipe_speed)
      $display("%0t: swipe_speed exp %0d got %0d", $time, e.swipe_speed, got.swipe_speed);
    if (got.swipe_length !== e.swipe_length)
      $display("%0t: swipe_length exp %0d got %0d", $time, e.swipe_length, got.swipe_length);
    if (got !== e) errors++;
  endfunction
endclass

module testbench;
  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  sgd_pkg::in_beat_t in_data;
  sgd_pkg::out_beat_t out_data;
  swipe_scoreboard board;
  bit calm;       // no idling in the last part of the run
  int sink_stall;

  swipe_gesture_detector dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("swipe_gesture_detector verification failed");
    $finish;
  end

  // Result side: random stall bursts on out_ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(1, 17);
        out_ready = 0;
        repeat (sink_stall) @(negedge clk);
      end
      out_ready = 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  task automatic write_reg(sgd_pkg::cfg_index_t idx, logic [15:0] v);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = v;
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send(sgd_pkg::req_type_t k, logic [11:0] x, logic [11:0] y,
                      logic [15:0] t);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1;
    in_data = '{req_type: k, pos_x: x, pos_y: y, tick_ms: t};
    // Ready only changes at rising edges, so its value here holds at the next one.
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    board.note_input(in_data);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // One stroke: down, ticks and moves near a line (now and then a random move), then up.
  task automatic stroke();
    int x, y, vx, vy, n;
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    vx = int'($urandom_range(0, 200)) - 100;
    vy = int'($urandom_range(0, 200)) - 100;
    send(sgd_pkg::REQ_DOWN, 12'(x), 12'(y), 16'($urandom));
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 1))
        send(sgd_pkg::REQ_TICK, 12'($urandom), 12'($urandom), 16'($urandom_range(0, 40)));
      x = x + vx + int'($urandom_range(0, 10)) - 5;
      y = y + vy + int'($urandom_range(0, 10)) - 5;
      x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
      y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
      if ($urandom_range(0, 9) == 0)
        send(sgd_pkg::REQ_MOVE, 12'($urandom), 12'($urandom), 16'($urandom));
      else send(sgd_pkg::REQ_MOVE, 12'(x), 12'(y), 16'($urandom));
    end
    send(sgd_pkg::REQ_UP, 12'($urandom), 12'($urandom), 16'($urandom));
  endtask

  initial begin
    board = new();
    rst = 1; cfg_we = 0; cfg_index = sgd_pkg::CFG_MIN_DIST; cfg_data = 0;
    in_valid = 0; in_data = '0; calm = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed: events before any down, extremes, turns, zero time.
    send(sgd_pkg::REQ_MOVE, 12'd0, 12'd0, 16'd0);
    send(sgd_pkg::REQ_UP, 12'd0, 12'd0, 16'd0);
    send(sgd_pkg::REQ_TICK, 12'hFFF, 12'hFFF, 16'hFFFF);
    send(sgd_pkg::REQ_MOVE, 12'hFFF, 12'hFFF, 16'hFFFF);
    send(sgd_pkg::REQ_UP, 12'd0, 12'd0, 16'd0);
    send(sgd_pkg::REQ_DOWN, 12'd0, 12'd0, 16'd0);
    send(sgd_pkg::REQ_MOVE, 12'd0, 12'd0, 16'd0);
    send(sgd_pkg::REQ_MOVE, 12'hFFF, 12'd0, 16'd0);
    send(sgd_pkg::REQ_MOVE, 12'hFFF, 12'hFFF, 16'd0);
    send(sgd_pkg::REQ_UP, 12'd0, 12'd0, 16'd0);
    drain();
    write_reg(sgd_pkg::CFG_ANGLE_EN, 16'd1);
    write_reg(sgd_pkg::CFG_COS_TOL, 16'd30000);
    write_reg(sgd_pkg::CFG_MIN_DIST, 16'd8191);
    write_reg(sgd_pkg::CFG_MIN_SPEED, 16'hFFFF);
    send(sgd_pkg::REQ_DOWN, 12'd100, 12'd100, 16'd0);
    send(sgd_pkg::REQ_TICK, 12'd0, 12'd0, 16'hFFFF);
    // Repeated maximal ticks saturate the elapsed time.
    repeat (257) send(sgd_pkg::REQ_TICK, 12'd0, 12'd0, 16'hFFFF);
    send(sgd_pkg::REQ_MOVE, 12'd200, 12'd100, 16'd0);
    send(sgd_pkg::REQ_MOVE, 12'd300, 12'd100, 16'd0);
    send(sgd_pkg::REQ_MOVE, 12'd300, 12'd100, 16'd0);
    send(sgd_pkg::REQ_MOVE, 12'd300, 12'd300, 16'd0);  // sharp turn, stroke dies
    send(sgd_pkg::REQ_MOVE, 12'd0, 12'd0, 16'd0);
    send(sgd_pkg::REQ_TICK, 12'd0, 12'd0, 16'd5);
    send(sgd_pkg::REQ_UP, 12'd0, 12'd0, 16'd0);
    drain();

    // Random phases with changing configuration, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(sgd_pkg::CFG_ANGLE_EN, 16'(ph % 3 != 0));
      write_reg(sgd_pkg::CFG_COS_TOL,
                ph == 1 ? 16'h8000 : (ph == 2 ? 16'h7FFF : 16'($urandom)));
      write_reg(sgd_pkg::CFG_MIN_DIST, ph == 3 ? 16'd8191 : 16'($urandom_range(0, 300)));
      write_reg(sgd_pkg::CFG_MIN_SPEED,
                ph == 4 ? 16'hFFFF : 16'($urandom_range(0, 20000)));
      if (ph == 7) calm = 1;
      for (int k = 0; k < 22; k++) begin
        if ($urandom_range(0, 7) == 0)
          send(sgd_pkg::req_type_t'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
               16'($urandom));
        else stroke();
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("swipe_gesture_detector verification clean");
    else
      $display("swipe_gesture_detector verification failed");
    $finish;
  end
endmodule
